// ----- rtl/core/vmap_pkg.sv -----
// Package for the volume mean axis projection block.
// Holds sizes, axis and register codes, the position bundle type and the extent clamp.
// No dependencies.
package vmap_pkg;

    localparam int MAX_X      = 256;
    localparam int MAX_Y      = 256;
    localparam int MAX_Z      = 256;
    localparam int POS_W      = 8;
    localparam int EXT_W      = 9;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int SUM_DEPTH  = MAX_X * MAX_Y;
    localparam int ADDR_W     = $clog2(SUM_DEPTH);
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              first;
        logic              axis_last;
        logic              vol_last;
        logic [EXT_W-1:0]  axis_len;
    } pos_info_t;

    // zero acts as one, values above the limit saturate
    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] v,
                                                    input logic [EXT_W-1:0] lim);
        logic [EXT_W-1:0] r;
        if (v == '0)
            r = EXT_W'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- rtl/core/vmap_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module vmap_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/vmap_raster.sv -----
// Raster position counters and decode of accumulator address and first/last flags.
// Depends on vmap_pkg.
module vmap_raster (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [1:0]                     axis,
    input  logic [vmap_pkg::EXT_W-1:0]     extent_x,
    input  logic [vmap_pkg::EXT_W-1:0]     extent_y,
    input  logic [vmap_pkg::EXT_W-1:0]     extent_z,
    output vmap_pkg::pos_info_t            info
);
    import vmap_pkg::*;

    logic [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [EXT_W-1:0] ex, ey, ez;
    logic             last_x, last_y, last_z;

    assign ex = eff_extent(extent_x, EXT_W'(MAX_X));
    assign ey = eff_extent(extent_y, EXT_W'(MAX_Y));
    assign ez = eff_extent(extent_z, EXT_W'(MAX_Z));

    assign last_x = ({1'b0, pos_x_reg} + EXT_W'(1)) >= ex;
    assign last_y = ({1'b0, pos_y_reg} + EXT_W'(1)) >= ey;
    assign last_z = ({1'b0, pos_z_reg} + EXT_W'(1)) >= ez;

    always_comb
    begin
        info.vol_last = last_x && last_y && last_z;
        unique case (axis) inside
            AXIS_X:
            begin
                info.addr      = '0;
                info.first     = (pos_x_reg == '0);
                info.axis_last = last_x;
                info.axis_len  = ex;
            end
            AXIS_Y:
            begin
                info.addr      = ADDR_W'(pos_x_reg);
                info.first     = (pos_y_reg == '0);
                info.axis_last = last_y;
                info.axis_len  = ey;
            end
            default:
            begin
                info.addr      = {pos_y_reg, pos_x_reg};
                info.first     = (pos_z_reg == '0);
                info.axis_last = last_z;
                info.axis_len  = ez;
            end
        endcase
    end

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (advance)
        begin
            if (last_x)
            begin
                pos_x_next = '0;
                if (last_y)
                begin
                    pos_y_next = '0;
                    pos_z_next = last_z ? '0 : pos_z_reg + POS_W'(1);
                end
                else
                begin
                    pos_y_next = pos_y_reg + POS_W'(1);
                end
            end
            else
            begin
                pos_x_next = pos_x_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

endmodule

// ----- rtl/core/vmap_div.sv -----
// Restoring divider, one quotient bit per cycle, for sum / axis extent.
// Depends on vmap_pkg.
module vmap_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vmap_pkg::SUM_W-1:0]    dividend,
    input  logic [vmap_pkg::EXT_W-1:0]    divisor,
    output logic                          busy,
    output logic [vmap_pkg::SUM_W-1:0]    quotient
);
    import vmap_pkg::*;

    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [EXT_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [EXT_W-1:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits  = (trial >= dsr_reg);

    always_comb
    begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? POS_W'(trial - dsr_reg) : POS_W'(trial);
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/volume_mean_axis_projection.sv -----
// Mean projection of a 3D volume along a configured axis.
// Voxels enter in raster order (x fastest, then y, then z) on voxel_valid/voxel_ready;
// one transfer per voxel. Means leave on result_valid/result_ready in the raster
// order of the 2D image, image_last marking the final pixel.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 axis, 1..3 extents x/y/z) and
// cfg_data; always ready; write only while the block is idle.
// Flow: a voxel is taken only while idle; the accumulator is read, then the add state
// writes the sum back through the single-port-pair RAM. A voxel that completes a pixel
// also starts the bit-serial divider, and its mean is then loaded into the output
// register. No new voxel is taken until the last one has been written back and, if it
// finished a pixel, its mean has been loaded.
// A result waits in the output register while the receiver stalls; the next voxel
// is still taken, and only a second result stalls behind it.
// Reset clears positions to the volume origin and registers to axis x, extents 256.
// The accumulator RAM needs no clearing: the first voxel along the axis writes it.
// Depends on vmap_pkg, vmap_ram, vmap_raster, vmap_div.
module volume_mean_axis_projection (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              voxel_valid,
    output logic                              voxel_ready,
    input  logic [vmap_pkg::SAMPLE_W-1:0]     voxel,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [vmap_pkg::SAMPLE_W-1:0]     mean_value,
    output logic                              image_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vmap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vmap_pkg::EXT_W-1:0]        cfg_data
);
    import vmap_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         axis_reg;
    logic [EXT_W-1:0]   extent_x_reg, extent_y_reg, extent_z_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    pos_info_t          info_reg;
    pos_info_t          pos_info;
    logic               out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic               last_reg, last_next;

    logic               accept;
    logic               out_free;
    logic [SUM_W-1:0]   rd_data;
    logic [SUM_W-1:0]   sum;
    logic               div_start;
    logic               div_busy;
    logic [SUM_W-1:0]   quotient;
    logic [SAMPLE_W-1:0] mean_sat;

    assign voxel_ready = (state_reg == ST_IDLE);
    assign accept      = voxel_valid && voxel_ready;
    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || result_ready;

    vmap_raster u_raster (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept),
        .axis     (axis_reg),
        .extent_x (extent_x_reg),
        .extent_y (extent_y_reg),
        .extent_z (extent_z_reg),
        .info     (pos_info)
    );

    assign sum = info_reg.first ? SUM_W'(sample_reg) : rd_data + SUM_W'(sample_reg);

    vmap_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sums (
        .clk     (clk),
        .wr_en   (state_reg == ST_ADD),
        .wr_addr (info_reg.addr),
        .wr_data (sum),
        .rd_en   (accept),
        .rd_addr (pos_info.addr),
        .rd_data (rd_data)
    );

    assign div_start = (state_reg == ST_ADD) && info_reg.axis_last;

    vmap_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .divisor  (info_reg.axis_len),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign mean_sat = (quotient[SUM_W-1:SAMPLE_W] != '0) ? '1 : quotient[SAMPLE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        mean_next      = mean_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = info_reg.axis_last ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = mean_sat;
                    last_next      = info_reg.vol_last;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            axis_reg      <= AXIS_X;
            extent_x_reg  <= EXT_W'(256);
            extent_y_reg  <= EXT_W'(256);
            extent_z_reg  <= EXT_W'(256);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_AXIS:     axis_reg     <= cfg_data[1:0];
                    REG_EXTENT_X: extent_x_reg <= cfg_data;
                    REG_EXTENT_Y: extent_y_reg <= cfg_data;
                    REG_EXTENT_Z: extent_z_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        last_reg <= last_next;
        if (accept)
        begin
            sample_reg <= voxel;
            info_reg   <= pos_info;
        end
    end

    assign result_valid = out_valid_reg;
    assign mean_value   = mean_reg;
    assign image_last   = last_reg;

endmodule
